// File: design/tbsc_pkg.sv
// Shared constants and types for the TFTP block sender control.
`timescale 1ns / 1ps

package tbsc_pkg;

  localparam int unsigned BLOCK_BYTES = 512;
  localparam int unsigned CHUNK_W = 10;
  localparam logic [CHUNK_W-1:0] HDR_BYTES = 10'd4;
  localparam logic [15:0] ACK_OPCODE = 16'd4;
  localparam logic [7:0] RETRY_LIMIT_RST = 8'd5;
  localparam logic [7:0] RETRY_SAT = 8'd255;

  localparam logic [1:0] KIND_START = 2'd0;
  localparam logic [1:0] KIND_REPLY = 2'd1;
  localparam logic [1:0] KIND_TIMEOUT = 2'd2;
  localparam logic [1:0] KIND_RX_ERROR = 2'd3;

  localparam logic [2:0] ACT_SEND = 3'd0;
  localparam logic [2:0] ACT_DONE = 3'd1;
  localparam logic [2:0] ACT_GAVE_UP = 3'd2;
  localparam logic [2:0] ACT_RX_FAIL = 3'd3;
  localparam logic [2:0] ACT_IDLE = 3'd4;

  typedef struct packed {
    logic               active;
    logic [31:0]        total_length;
    logic [31:0]        send_offset;
    logic [15:0]        current_block;
    logic [CHUNK_W-1:0] current_chunk;
    logic [7:0]         timeouts_seen;
  } sender_state_t;

  typedef struct packed {
    logic [2:0]         action;
    logic [15:0]        blk_num;
    logic [31:0]        byte_offset;
    logic [CHUNK_W-1:0] chunk_length;
    logic [CHUNK_W-1:0] packet_length;
    logic               is_resend;
    logic [7:0]         retry_count;
  } result_t;

  function automatic logic [CHUNK_W-1:0] chunk_of(input logic [31:0] total,
                                                   input logic [31:0] offset);
    logic [31:0] left;
    left = total - offset;
    if (left > 32'(BLOCK_BYTES)) begin
      chunk_of = CHUNK_W'(BLOCK_BYTES);
    end else begin
      chunk_of = left[CHUNK_W-1:0];
    end
  endfunction

endpackage

// File: design/tbsc_step.sv
// Next-state and result logic for one request of the TFTP block sender.
`timescale 1ns / 1ps

module tbsc_step (
  input  tbsc_pkg::sender_state_t cur,
  input  logic [7:0]              retry_limit,
  input  logic [1:0]              kind,
  input  logic [31:0]             transfer_length,
  input  logic [15:0]             reply_opcode,
  input  logic [15:0]             reply_block,
  input  logic                    reply_short,
  output tbsc_pkg::sender_state_t nxt,
  output tbsc_pkg::result_t       res
);

  logic [7:0]                       ts_inc;
  logic [31:0]                      off_adv;
  logic [15:0]                      blk_adv;
  logic [2:0]                       act;
  logic                             resend;
  logic                             ack_ok;
  tbsc_pkg::sender_state_t          s;
  tbsc_pkg::sender_state_t          rep;

  assign ts_inc  = (cur.timeouts_seen < tbsc_pkg::RETRY_SAT) ? cur.timeouts_seen + 8'd1
                                                              : cur.timeouts_seen;
  assign off_adv = cur.send_offset + 32'(cur.current_chunk);
  assign blk_adv = cur.current_block + 16'd1;
  assign ack_ok  = !reply_short && (reply_opcode == tbsc_pkg::ACK_OPCODE) &&
                   (reply_block == cur.current_block);

  always_comb begin
    s      = cur;
    rep    = cur;
    act    = tbsc_pkg::ACT_IDLE;
    resend = 1'b0;
    if (kind == tbsc_pkg::KIND_START) begin
      s.active        = 1'b1;
      s.total_length  = transfer_length;
      s.send_offset   = 32'd0;
      s.current_block = 16'd1;
      s.timeouts_seen = 8'd0;
      s.current_chunk = tbsc_pkg::chunk_of(transfer_length, 32'd0);
      rep             = s;
      act             = tbsc_pkg::ACT_SEND;
    end else if (!cur.active) begin
      act = tbsc_pkg::ACT_IDLE;
    end else begin
      case (kind)
        tbsc_pkg::KIND_RX_ERROR: begin
          s.active = 1'b0;
          act      = tbsc_pkg::ACT_RX_FAIL;
        end
        tbsc_pkg::KIND_TIMEOUT: begin
          s.timeouts_seen   = ts_inc;
          rep.timeouts_seen = ts_inc;
          if (ts_inc >= retry_limit) begin
            s.active = 1'b0;
            act      = tbsc_pkg::ACT_GAVE_UP;
          end else begin
            act    = tbsc_pkg::ACT_SEND;
            resend = 1'b1;
          end
        end
        default: begin
          if (!ack_ok) begin
            act    = tbsc_pkg::ACT_SEND;
            resend = 1'b1;
          end else if (32'(cur.current_chunk) < 32'(tbsc_pkg::BLOCK_BYTES)) begin
            s.active        = 1'b0;
            s.send_offset   = off_adv;
            s.current_block = blk_adv;
            act             = tbsc_pkg::ACT_DONE;
          end else begin
            s.send_offset   = off_adv;
            s.current_block = blk_adv;
            s.timeouts_seen = 8'd0;
            s.current_chunk = tbsc_pkg::chunk_of(cur.total_length, off_adv);
            rep             = s;
            act             = tbsc_pkg::ACT_SEND;
          end
        end
      endcase
    end
  end

  assign nxt = s;

  always_comb begin
    res.action        = act;
    res.blk_num       = rep.current_block;
    res.byte_offset   = rep.send_offset;
    res.chunk_length  = rep.current_chunk;
    res.packet_length = tbsc_pkg::HDR_BYTES + rep.current_chunk;
    res.is_resend     = resend;
    res.retry_count   = rep.timeouts_seen;
  end

endmodule

// File: design/tbsc_out_queue.sv
// Two-entry result buffer: an output register backed by a skid register.
`timescale 1ns / 1ps

module tbsc_out_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  tbsc_pkg::result_t push_data,
  output logic              full,
  output logic              out_valid,
  input  logic              out_stall,
  output tbsc_pkg::result_t out_data
);

  logic              main_valid_r;
  logic              main_valid_nxt;
  logic              skid_valid_r;
  logic              skid_valid_nxt;
  tbsc_pkg::result_t main_r;
  tbsc_pkg::result_t skid_r;
  logic              take;

  assign take = main_valid_r && !out_stall;

  always_comb begin
    main_valid_nxt = main_valid_r;
    skid_valid_nxt = skid_valid_r;
    if (take) begin
      if (skid_valid_r) begin
        skid_valid_nxt = 1'b0;
      end else begin
        main_valid_nxt = push;
      end
    end else if (push) begin
      if (main_valid_r) begin
        skid_valid_nxt = 1'b1;
      end else begin
        main_valid_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      main_valid_r <= main_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take && skid_valid_r) begin
      main_r <= skid_r;
    end else if (push && (take || !main_valid_r)) begin
      main_r <= push_data;
    end
    if (push && main_valid_r && !take) begin
      skid_r <= push_data;
    end
  end

  assign full      = skid_valid_r;
  assign out_valid = main_valid_r;
  assign out_data  = main_r;

  a_skid_needs_main: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> main_valid_r)
    else $error("skid entry held without an output entry");

  a_push_lands: assert property (@(posedge clk) disable iff (!rst_n)
    push |=> main_valid_r)
    else $error("accepted request produced no pending result");

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> !push)
    else $error("request pushed into a full result buffer");

endmodule

// File: design/tftp_block_sender_control.sv
// Top level of the stop-and-wait TFTP data sender controller.
// A request's result is registered in the result buffer's output or skid register.
// Throughput: one request per cycle; a two-entry result buffer lets a request be
// accepted while one result waits, and in_stall rises only when both entries are full.
// Reset: synchronous active-low; the transfer goes inactive, block number 1, all
// counts zero, retry limit 5, and the result buffer empties.
`timescale 1ns / 1ps

module tftp_block_sender_control (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_kind,
  input  logic [31:0] in_transfer_length,
  input  logic [15:0] in_reply_opcode,
  input  logic [15:0] in_reply_block,
  input  logic        in_reply_short,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_action,
  output logic [15:0] out_blk_num,
  output logic [31:0] out_byte_offset,
  output logic [9:0]  out_chunk_length,
  output logic [9:0]  out_packet_length,
  output logic        out_is_resend,
  output logic [7:0]  out_retry_count
);

  logic [7:0]              retry_limit_r;
  tbsc_pkg::sender_state_t state_r;
  tbsc_pkg::sender_state_t state_nxt;
  tbsc_pkg::result_t       step_res;
  tbsc_pkg::result_t       out_data;
  logic                    accept;
  logic                    full;

  assign in_stall = full;
  assign accept   = in_valid && !full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      retry_limit_r <= tbsc_pkg::RETRY_LIMIT_RST;
    end else if (cfg_wr_en) begin
      retry_limit_r <= cfg_wr_data;
    end
  end

  tbsc_step u_step (
    .cur             (state_r),
    .retry_limit     (retry_limit_r),
    .kind            (in_kind),
    .transfer_length (in_transfer_length),
    .reply_opcode    (in_reply_opcode),
    .reply_block     (in_reply_block),
    .reply_short     (in_reply_short),
    .nxt             (state_nxt),
    .res             (step_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.active        <= 1'b0;
      state_r.total_length  <= 32'd0;
      state_r.send_offset   <= 32'd0;
      state_r.current_block <= 16'd1;
      state_r.current_chunk <= '0;
      state_r.timeouts_seen <= 8'd0;
    end else if (accept) begin
      state_r <= state_nxt;
    end
  end

  tbsc_out_queue u_out_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept),
    .push_data (step_res),
    .full      (full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  assign out_action        = out_data.action;
  assign out_blk_num       = out_data.blk_num;
  assign out_byte_offset   = out_data.byte_offset;
  assign out_chunk_length  = out_data.chunk_length;
  assign out_packet_length = out_data.packet_length;
  assign out_is_resend     = out_data.is_resend;
  assign out_retry_count   = out_data.retry_count;

  a_chunk_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(state_r.current_chunk) <= 32'(tbsc_pkg::BLOCK_BYTES))
    else $error("stored chunk exceeds the block size");

  a_start_activates: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_kind == tbsc_pkg::KIND_START) |=> state_r.active)
    else $error("start request left the transfer inactive");

  a_idle_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !state_r.active && in_kind != tbsc_pkg::KIND_START)
      |=> $stable(state_r))
    else $error("inactive request changed the sender state");

endmodule
